### sv/sdci_pkg.sv
// Shared types and constants of the SD card bring-up sequencer.
`default_nettype none
package sdci_pkg;

  // Input item kinds.
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_DONE   = 2'd2;

  // Controller command encodings.
  localparam logic [19:0] CMD_GO_IDLE   = 20'h00000;
  localparam logic [19:0] CMD_IF_COND   = 20'h10408;
  localparam logic [19:0] CMD_APP       = 20'h10437;
  localparam logic [19:0] CMD_OP_COND   = 20'h10769;
  localparam logic [19:0] CMD_ALL_CID   = 20'h10602;
  localparam logic [19:0] CMD_SEND_RCA  = 20'h10403;
  localparam logic [19:0] CMD_SEND_CSD  = 20'h10609;
  localparam logic [19:0] CMD_SELECT    = 20'h10507;
  localparam logic [19:0] CMD_SET_DETECT = 20'h1076A;
  localparam logic [19:0] CMD_BUS_WIDTH = 20'h10446;
  localparam logic [19:0] CMD_SWITCH    = 20'h31C06;
  localparam logic [19:0] CMD_STATUS    = 20'h1040D;
  localparam logic [19:0] CMD_BLOCKLEN  = 20'h10410;

  // Command arguments.
  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [31:0] ARG_OP_COND   = 32'h1010_0000;
  localparam logic [31:0] ARG_SWITCH_HS = 32'h80FF_FFF1;
  localparam logic [31:0] ARG_WIDE_BUS  = 32'h0000_0002;
  localparam logic [31:0] ARG_BLOCK_512 = 32'h0000_0200;

  // Clock divider codes.
  localparam logic [9:0] CLK_IDENT  = 10'h020;
  localparam logic [9:0] CLK_NORMAL = 10'h201;
  localparam logic [9:0] CLK_HIGH   = 10'h200;

  localparam logic [9:0] BLKLEN_SWITCH  = 10'd64;
  localparam logic [9:0] BLKLEN_DEFAULT = 10'd512;

  // Final status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NO_CARD  = 4'd1;
  localparam logic [3:0] ST_F_CMD2   = 4'd2;
  localparam logic [3:0] ST_F_CMD3   = 4'd3;
  localparam logic [3:0] ST_F_CMD9   = 4'd4;
  localparam logic [3:0] ST_F_CMD7   = 4'd5;
  localparam logic [3:0] ST_F_APP42  = 4'd6;
  localparam logic [3:0] ST_F_ACMD42 = 4'd7;
  localparam logic [3:0] ST_F_APP6   = 4'd8;
  localparam logic [3:0] ST_F_ACMD6  = 4'd9;
  localparam logic [3:0] ST_F_CMD6   = 4'd10;
  localparam logic [3:0] ST_F_CMD13  = 4'd11;
  localparam logic [3:0] ST_F_CMD16  = 4'd12;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd50;

  // Fields decoded from a CSD response.
  typedef struct packed {
    logic        switch_supported;
    logic [31:0] capacity;
  } csd_info_t;

endpackage
`default_nettype wire

### sv/sdci_csd_decode.sv
// CSD decoder: card capacity in sectors and command-switch support.
`default_nettype none
module sdci_csd_decode (
  input  wire logic [31:0]      resp_w1_i,
  input  wire logic [31:0]      resp_w2_i,
  input  wire logic [31:0]      resp_w3_i,
  output sdci_pkg::csd_info_t   info_o
);

  logic [1:0]  structure;
  logic [3:0]  read_bl_len;
  logic [2:0]  size_mult;
  logic [11:0] c_size_v1;
  logic [12:0] c_size_v1_p1;
  logic [4:0]  shift_v1;
  logic [36:0] bytes_v1;
  logic [21:0] c_size_v2;
  logic [22:0] c_size_v2_p1;
  logic [32:0] sectors_v2;

  assign structure    = resp_w3_i[23:22];
  assign read_bl_len  = resp_w2_i[11:8];
  assign size_mult    = {resp_w1_i[9:8], resp_w1_i[7]};
  assign c_size_v1    = {resp_w2_i[1:0], resp_w1_i[31:24], resp_w1_i[23:22]};
  assign c_size_v1_p1 = {1'b0, c_size_v1} + 13'd1;
  assign shift_v1     = 5'({2'b00, size_mult}) + 5'd2 + 5'({1'b0, read_bl_len});
  assign bytes_v1     = {24'd0, c_size_v1_p1} << shift_v1;

  assign c_size_v2    = {resp_w1_i[29:24], resp_w1_i[23:16], resp_w1_i[15:8]};
  assign c_size_v2_p1 = {1'b0, c_size_v2} + 23'd1;
  assign sectors_v2   = {c_size_v2_p1, 10'd0};

  always_comb begin
    info_o.switch_supported = resp_w2_i[22];
    case (structure)
      2'd0:    info_o.capacity = {4'd0, bytes_v1[36:9]};
      2'd1:    info_o.capacity = sectors_v2[32] ? 32'hFFFF_FFFF : sectors_v2[31:0];
      default: info_o.capacity = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### sv/sd_card_init_sequencer.sv
// Top level of the SD card bring-up sequencer.
//
// Input items (start, card-detect sample, command completion with its
// response words) arrive on a valid/ready channel; every accepted item
// gives exactly one result item on the output valid/ready channel. A
// result carries the next command to issue, the clock code, bus width and
// block length, and on the last step of a run the final status, the SDHC
// flag and the capacity in sectors.
// An item is captured in an input register and stepped through the
// sequencer into the result register, where the result waits until it
// is taken. One item is taken every cycle while the receiver keeps up;
// when it stalls, the held result and one captured item wait and the
// input side deasserts ready.
// Reset puts the sequencer idle, resets all run state and loads the poll
// limit register with 50. The limit is to be written through cfg_we_i and
// cfg_wdata_i only while the block is idle, which the block does not
// enforce; a start item restarts a run at any point.
`default_nettype none
module sd_card_init_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic        card_present_i,
  input  wire logic        hard_error_i,
  input  wire logic        resp_end_i,
  input  wire logic [31:0] resp_w0_i,
  input  wire logic [31:0] resp_w1_i,
  input  wire logic [31:0] resp_w2_i,
  input  wire logic [31:0] resp_w3_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             issue_command_o,
  output logic [19:0]      command_word_o,
  output logic [31:0]      command_arg_o,
  output logic [9:0]       clock_setting_o,
  output logic             wide_bus_o,
  output logic [9:0]       block_length_o,
  output logic             done_res_o,
  output logic [3:0]       status_o,
  output logic             is_high_capacity_o,
  output logic [31:0]      capacity_sectors_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_POLL   = 5'd1;
  localparam logic [4:0] S_CMD0   = 5'd2;
  localparam logic [4:0] S_CMD8   = 5'd3;
  localparam logic [4:0] S_LOOP55 = 5'd4;
  localparam logic [4:0] S_ACMD41 = 5'd5;
  localparam logic [4:0] S_CMD2   = 5'd6;
  localparam logic [4:0] S_CMD3   = 5'd7;
  localparam logic [4:0] S_CMD9   = 5'd8;
  localparam logic [4:0] S_CMD7   = 5'd9;
  localparam logic [4:0] S_APP42  = 5'd10;
  localparam logic [4:0] S_ACMD42 = 5'd11;
  localparam logic [4:0] S_APP6   = 5'd12;
  localparam logic [4:0] S_ACMD6  = 5'd13;
  localparam logic [4:0] S_CMD6   = 5'd14;
  localparam logic [4:0] S_CMD13  = 5'd15;
  localparam logic [4:0] S_CMD16  = 5'd16;

  logic [7:0] limit_q;

  // Input register.
  logic        in_valid_q;
  logic [1:0]  act_q;
  logic        present_q;
  logic        hard_q;
  logic        resp_end_q;
  logic [31:0] w0_q, w1_q, w2_q, w3_q;

  // Sequencer state.
  logic [4:0]  stage_q, stage_d;
  logic [7:0]  poll_q, poll_d;
  logic [15:0] rca_q, rca_d;
  logic        v2_q, v2_d;
  logic        sw_q, sw_d;
  logic        hc_q, hc_d;
  logic [31:0] cap_q, cap_d;
  logic [9:0]  clk_code_q, clk_code_d;
  logic        bus_q, bus_d;

  // Result register.
  logic        out_valid_q;
  logic        issue_q, issue_d;
  logic [19:0] word_q, word_d;
  logic [31:0] arg_q, arg_d;
  logic        done_q, done_d;
  logic [3:0]  status_q, status_d;

  logic        step;
  logic        resp_seen;
  logic [31:0] rca_arg;
  logic [7:0]  poll_inc;
  logic [3:0]  fail;
  sdci_pkg::csd_info_t csd;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  sdci_csd_decode u_csd (
    .resp_w1_i (w1_q),
    .resp_w2_i (w2_q),
    .resp_w3_i (w3_q),
    .info_o    (csd)
  );

  assign resp_seen = resp_end_q && !hard_q;
  assign rca_arg   = {rca_q, 16'd0};
  assign poll_inc  = poll_q + 8'd1;

  always_comb begin
    stage_d    = stage_q;
    poll_d     = poll_q;
    rca_d      = rca_q;
    v2_d       = v2_q;
    sw_d       = sw_q;
    hc_d       = hc_q;
    cap_d      = cap_q;
    clk_code_d = clk_code_q;
    bus_d      = bus_q;
    issue_d    = 1'b0;
    word_d     = 20'd0;
    arg_d      = 32'd0;
    done_d     = 1'b0;
    status_d   = sdci_pkg::ST_OK;
    fail       = sdci_pkg::ST_OK;

    case (act_q)
      sdci_pkg::ACT_START: begin
        poll_d     = 8'd0;
        rca_d      = 16'd0;
        v2_d       = 1'b0;
        sw_d       = 1'b0;
        hc_d       = 1'b0;
        cap_d      = 32'd0;
        clk_code_d = sdci_pkg::CLK_IDENT;
        bus_d      = 1'b0;
        stage_d    = S_POLL;
      end
      sdci_pkg::ACT_SAMPLE: begin
        if (stage_q == S_POLL) begin
          if (present_q) begin
            issue_d = 1'b1;
            word_d  = sdci_pkg::CMD_GO_IDLE;
            stage_d = S_CMD0;
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= limit_q) begin
              done_d   = 1'b1;
              status_d = sdci_pkg::ST_NO_CARD;
              stage_d  = S_IDLE;
            end
          end
        end
      end
      sdci_pkg::ACT_DONE: begin
        case (stage_q)
          S_CMD0: begin
            issue_d = 1'b1; word_d = sdci_pkg::CMD_IF_COND;
            arg_d = sdci_pkg::ARG_IF_COND; stage_d = S_CMD8;
          end
          S_CMD8: begin
            v2_d = resp_seen;
            issue_d = 1'b1; word_d = sdci_pkg::CMD_APP; arg_d = rca_arg;
            stage_d = S_LOOP55;
          end
          S_LOOP55: begin
            issue_d = 1'b1; word_d = sdci_pkg::CMD_OP_COND;
            arg_d = sdci_pkg::ARG_OP_COND | {1'b0, v2_q, 30'd0};
            stage_d = S_ACMD41;
          end
          S_ACMD41: begin
            issue_d = 1'b1;
            if (resp_seen && w0_q[31]) begin
              hc_d = w0_q[30] && v2_q;
              word_d = sdci_pkg::CMD_ALL_CID; stage_d = S_CMD2;
            end else begin
              word_d = sdci_pkg::CMD_APP; arg_d = rca_arg; stage_d = S_LOOP55;
            end
          end
          S_CMD2: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD2;
            end else begin
              issue_d = 1'b1; word_d = sdci_pkg::CMD_SEND_RCA; stage_d = S_CMD3;
            end
          end
          S_CMD3: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD3;
            end else begin
              rca_d = w0_q[31:16];
              issue_d = 1'b1; word_d = sdci_pkg::CMD_SEND_CSD;
              arg_d = {w0_q[31:16], 16'd0}; stage_d = S_CMD9;
            end
          end
          S_CMD9: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD9;
            end else begin
              sw_d = csd.switch_supported;
              cap_d = csd.capacity;
              clk_code_d = sdci_pkg::CLK_NORMAL;
              issue_d = 1'b1; word_d = sdci_pkg::CMD_SELECT; arg_d = rca_arg;
              stage_d = S_CMD7;
            end
          end
          S_CMD7: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD7;
            end else begin
              issue_d = 1'b1; word_d = sdci_pkg::CMD_APP; arg_d = rca_arg;
              stage_d = S_APP42;
            end
          end
          S_APP42: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_APP42;
            end else begin
              issue_d = 1'b1; word_d = sdci_pkg::CMD_SET_DETECT; stage_d = S_ACMD42;
            end
          end
          S_ACMD42: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_ACMD42;
            end else begin
              issue_d = 1'b1; word_d = sdci_pkg::CMD_APP; arg_d = rca_arg;
              stage_d = S_APP6;
            end
          end
          S_APP6: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_APP6;
            end else begin
              issue_d = 1'b1; word_d = sdci_pkg::CMD_BUS_WIDTH;
              arg_d = sdci_pkg::ARG_WIDE_BUS; stage_d = S_ACMD6;
            end
          end
          S_ACMD6: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_ACMD6;
            end else begin
              bus_d = 1'b1;
              issue_d = 1'b1;
              if (sw_q) begin
                word_d = sdci_pkg::CMD_SWITCH; arg_d = sdci_pkg::ARG_SWITCH_HS;
                stage_d = S_CMD6;
              end else begin
                clk_code_d = sdci_pkg::CLK_NORMAL;
                word_d = sdci_pkg::CMD_STATUS; arg_d = rca_arg; stage_d = S_CMD13;
              end
            end
          end
          S_CMD6: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD6;
            end else begin
              clk_code_d = sdci_pkg::CLK_HIGH;
              issue_d = 1'b1; word_d = sdci_pkg::CMD_STATUS; arg_d = rca_arg;
              stage_d = S_CMD13;
            end
          end
          S_CMD13: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD13;
            end else begin
              issue_d = 1'b1; word_d = sdci_pkg::CMD_BLOCKLEN;
              arg_d = sdci_pkg::ARG_BLOCK_512; stage_d = S_CMD16;
            end
          end
          S_CMD16: begin
            if (hard_q) begin
              fail = sdci_pkg::ST_F_CMD16;
            end else begin
              done_d = 1'b1; status_d = sdci_pkg::ST_OK; stage_d = S_IDLE;
            end
          end
          default: begin
          end
        endcase
        // A hard error on any checked command ends the run with its stage code.
        if (fail != sdci_pkg::ST_OK) begin
          done_d   = 1'b1;
          status_d = fail;
          stage_d  = S_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sdci_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      act_q      <= action_i;
      present_q  <= card_present_i;
      hard_q     <= hard_error_i;
      resp_end_q <= resp_end_i;
      w0_q       <= resp_w0_i;
      w1_q       <= resp_w1_i;
      w2_q       <= resp_w2_i;
      w3_q       <= resp_w3_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= S_IDLE;
      poll_q     <= 8'd0;
      rca_q      <= 16'd0;
      v2_q       <= 1'b0;
      sw_q       <= 1'b0;
      hc_q       <= 1'b0;
      cap_q      <= 32'd0;
      clk_code_q <= sdci_pkg::CLK_IDENT;
      bus_q      <= 1'b0;
    end else if (step) begin
      stage_q    <= stage_d;
      poll_q     <= poll_d;
      rca_q      <= rca_d;
      v2_q       <= v2_d;
      sw_q       <= sw_d;
      hc_q       <= hc_d;
      cap_q      <= cap_d;
      clk_code_q <= clk_code_d;
      bus_q      <= bus_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      issue_q  <= issue_d;
      word_q   <= word_d;
      arg_q    <= arg_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // The state registers update together with the result register, so the
  // reported settings are those left by the step that made the result.
  assign out_valid_o        = out_valid_q;
  assign issue_command_o    = issue_q;
  assign command_word_o     = word_q;
  assign command_arg_o      = arg_q;
  assign clock_setting_o    = clk_code_q;
  assign wide_bus_o         = bus_q;
  assign block_length_o     = (stage_q == S_CMD6) ? sdci_pkg::BLKLEN_SWITCH
                                                  : sdci_pkg::BLKLEN_DEFAULT;
  assign done_res_o         = done_q;
  assign status_o           = status_q;
  assign is_high_capacity_o = hc_q;
  assign capacity_sectors_o = cap_q;

endmodule
`default_nettype wire
